// ----- rtl/circular_fifo_with_search_top_defines.svh -----
// Assertion macros used by the top level of the searchable ring-buffer FIFO.
`ifndef CIRCULAR_FIFO_WITH_SEARCH_TOP_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define CFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfs assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfs assertion failed");

`else

`define CFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/cfs_pkg.sv -----
// Types, constants and helpers for the searchable ring-buffer FIFO.
package cfs_pkg;

    localparam int DEPTH  = 128;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int OCC_W  = 8;

    typedef logic [AW-1:0]     t_addr;
    typedef logic [CW-1:0]     t_count;
    typedef logic [DATA_W-1:0] t_word;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_SEARCH = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_mode                     mode;
        logic signed [DATA_W-1:0]  value;
    } t_req;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  data;
        logic [POS_W-1:0]          position;
        logic [OCC_W-1:0]          occupancy;
        logic                      is_empty;
        logic                      is_full;
    } t_rsp;

    localparam t_addr  LAST_IDX  = AW'(DEPTH - 1);
    localparam t_count FILL_FULL = CW'(DEPTH);

    // Ring increment that wraps at the last slot.
    function automatic t_addr next_idx(t_addr idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

endpackage

// ----- rtl/cfs_ram.sv -----
// Word storage of the FIFO: one write port and one registered read port.
module cfs_ram (
    input  logic           i_clk,
    input  logic           i_we,
    input  cfs_pkg::t_addr i_waddr,
    input  cfs_pkg::t_word i_wdata,
    input  logic           i_re,
    input  cfs_pkg::t_addr i_raddr,
    output cfs_pkg::t_word o_rdata
);
    import cfs_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/circular_fifo_with_search_top.sv -----
// Top level of the ring-buffer FIFO of signed words with push, pop, peek and search.
// The result register is loaded when a request finishes in EXEC. Push, pop and peek
// finish at their first EXEC step; a search reads one stored word per cycle through the
// single read port of the storage RAM until it hits or has passed every stored word.
// A new request is taken only in IDLE. A full result register stalls the finishing step.
// Reset (synchronous, active low) empties the queue; the storage itself is not cleared.
`include "circular_fifo_with_search_top_defines.svh"

module circular_fifo_with_search_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cfs_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cfs_pkg::t_rsp o_out_data
);
    import cfs_pkg::*;

    // The sequencer has two states. In IDLE it takes a request and at the same
    // edge starts a read of the head slot, so the head word is ready in EXEC.
    // EXEC finishes push, pop and peek at once when the result register is free; for a
    // search it compares one stored word per cycle against the key, fetching the next one.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state  r_state,     n_state;
    t_addr   r_head,      n_head;
    t_addr   r_tail,      n_tail;
    t_count  r_fill,      n_fill;
    t_mode   r_mode,      n_mode;
    t_word   r_key,       n_key;
    t_count  r_k,         n_k;
    t_addr   r_scan,      n_scan;
    logic    r_out_valid, n_out_valid;
    t_rsp    r_out,       n_out;

    // Storage port signals.
    logic    w_mem_we;
    logic    w_mem_re;
    t_addr   w_mem_raddr;
    t_word   w_rd_data;

    // Result of the current step in EXEC.
    logic    w_done;
    logic    w_commit;
    logic    w_out_free;
    logic    w_push_ok;
    logic    w_pop_ok;
    t_status w_status;
    t_word   w_data;
    t_count  w_pos;
    t_count  w_new_fill;

    cfs_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_tail),
        .i_wdata (r_key),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rd_data)
    );

    // The result register frees up when its contents are taken in this cycle.
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_mode      = r_mode;
        n_key       = r_key;
        n_k         = r_k;
        n_scan      = r_scan;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_raddr = r_head;
        w_done      = 1'b0;
        w_commit    = 1'b0;
        w_push_ok   = 1'b0;
        w_pop_ok    = 1'b0;
        w_status    = ST_OK;
        w_data      = '0;
        w_pos       = '0;
        w_new_fill  = r_fill;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode      = i_in_data.mode;
                    n_key       = t_word'(i_in_data.value);
                    n_k         = '0;
                    n_scan      = next_idx(r_head);
                    w_mem_re    = 1'b1;
                    w_mem_raddr = r_head;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_mode)
                    MODE_PUSH: begin
                        w_done = 1'b1;
                        if (r_fill == FILL_FULL) begin
                            w_status = ST_FULL;
                        end else begin
                            w_push_ok  = 1'b1;
                            w_new_fill = r_fill + CW'(1);
                        end
                    end
                    MODE_POP: begin
                        w_done = 1'b1;
                        if (r_fill == '0) begin
                            w_status = ST_EMPTY;
                        end else begin
                            w_pop_ok   = 1'b1;
                            w_data     = w_rd_data;
                            w_new_fill = r_fill - CW'(1);
                        end
                    end
                    MODE_PEEK: begin
                        w_done = 1'b1;
                        if (r_fill == '0) begin
                            w_status = ST_EMPTY;
                        end else begin
                            w_data = w_rd_data;
                        end
                    end
                    MODE_SEARCH: begin
                        if (r_k >= r_fill) begin
                            w_done   = 1'b1;
                            w_status = ST_NOTFOUND;
                        end else if (w_rd_data == r_key) begin
                            w_done = 1'b1;
                            w_pos  = r_k;
                        end else begin
                            // No match yet: fetch the next slot of the ring.
                            w_mem_re    = 1'b1;
                            w_mem_raddr = r_scan;
                            n_scan      = next_idx(r_scan);
                            n_k         = r_k + CW'(1);
                        end
                    end
                endcase

                // State changes only when the result can be handed over.
                if (w_done && w_out_free) begin
                    w_commit = 1'b1;
                    n_fill   = w_new_fill;
                    if (w_push_ok) begin
                        w_mem_we = 1'b1;
                        n_tail   = next_idx(r_tail);
                    end
                    if (w_pop_ok) begin
                        n_head = next_idx(r_head);
                    end
                    n_out.status    = w_status;
                    n_out.data      = $signed(w_data);
                    n_out.position  = POS_W'(w_pos);
                    n_out.occupancy = OCC_W'(w_new_fill);
                    n_out.is_empty  = (w_new_fill == '0);
                    n_out.is_full   = (w_new_fill == FILL_FULL);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_mode <= n_mode;
        r_key  <= n_key;
        r_k    <= n_k;
        r_scan <= n_scan;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An empty or a full ring has its head and tail on the same slot.
    `CFS_ASSERT_IMPL(a_ring_ptrs, i_clk, i_rst_n, (r_fill == '0 || r_fill == FILL_FULL), r_head == r_tail)
    // The fill count moves only when a request finishes.
    `CFS_ASSERT_NEXT(a_fill_hold, i_clk, i_rst_n, !w_commit, $stable(r_fill))
    // A finished request always leaves a result behind.
    `CFS_ASSERT_NEXT(a_commit_out, i_clk, i_rst_n, w_commit, o_out_valid && r_state == S_IDLE)
    // A search never walks past the stored words.
    `CFS_ASSERT_IMPL(a_scan_bound, i_clk, i_rst_n, r_state == S_EXEC, r_k <= r_fill)

endmodule

// ----- bench/cfs_result_monitor.sv -----
// Response predictor and comparator for the searchable ring-buffer FIFO.
module cfs_result_monitor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  cfs_pkg::t_req i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  cfs_pkg::t_rsp i_out_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked,
    output int            o_full_rejects,
    output int            o_empty_rejects
);
    import cfs_pkg::*;

    // Shadow copy of the queue contents and pointers.
    t_word  shadow_words [DEPTH];
    int     shadow_head;
    int     shadow_tail;
    int     shadow_fill;

    t_rsp   pending_rsps [$];
    t_rsp   oldest_rsp;

    // Applies one request to the shadow queue and returns the response it must produce.
    function automatic t_rsp predict_fifo_op(t_req req);
        t_rsp rsp;
        int   idx;
        bit   hit;
        rsp        = '0;
        rsp.status = ST_OK;
        case (req.mode)
            MODE_PUSH: begin
                if (shadow_fill >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    shadow_words[shadow_tail] = req.value;
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_fill++;
                end
            end
            MODE_POP, MODE_PEEK: begin
                if (shadow_fill == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.data = shadow_words[shadow_head];
                    if (req.mode == MODE_POP) begin
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_fill--;
                    end
                end
            end
            default: begin
                hit = 1'b0;
                idx = shadow_head;
                for (int k = 0; k < shadow_fill && !hit; k++) begin
                    if (shadow_words[idx] == req.value) begin
                        hit          = 1'b1;
                        rsp.position = POS_W'(k);
                    end
                    idx = (idx + 1) % DEPTH;
                end
                if (!hit) rsp.status = ST_NOTFOUND;
            end
        endcase
        rsp.occupancy = OCC_W'(shadow_fill);
        rsp.is_empty  = (shadow_fill == 0);
        rsp.is_full   = (shadow_fill == DEPTH);
        return rsp;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_head = 0;
            shadow_tail = 0;
            shadow_fill = 0;
            pending_rsps.delete();
        end else begin
            // The expectation is queued first so a response in the same cycle as its request would still line up.
            if (i_in_valid && i_in_ready) begin
                pending_rsps.insert(pending_rsps.size(), predict_fifo_op(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_rsps.size() == 0) begin
                    $error("response with no outstanding request: %p", i_out_data);
                    o_fail_count++;
                end else begin
                    oldest_rsp = pending_rsps.pop_front();
                    o_checked++;
                    if (oldest_rsp.status == ST_FULL) o_full_rejects++;
                    if (oldest_rsp.status == ST_EMPTY) o_empty_rejects++;
                    compare_field("status", oldest_rsp.status, i_out_data.status);
                    compare_field("data", oldest_rsp.data, i_out_data.data);
                    compare_field("position", oldest_rsp.position, i_out_data.position);
                    compare_field("occupancy", oldest_rsp.occupancy, i_out_data.occupancy);
                    compare_field("is_empty", oldest_rsp.is_empty, i_out_data.is_empty);
                    compare_field("is_full", oldest_rsp.is_full, i_out_data.is_full);
                end
            end
        end
        o_pending = pending_rsps.size();
    end

endmodule

// ----- bench/testbench.sv -----
// Stimulus, flow control and verdict for the searchable ring-buffer FIFO.
module testbench;
    import cfs_pkg::*;

    // A run with no handshake on either side for this many cycles is hung. The slowest
    // legal gap is a deep search behind the long receiver hold-off.
    localparam int STALL_LIMIT = 2000;
    // Length of the receiver hold-off that backs the block up against its input.
    localparam int HOLD_CYCLES = 300;

    logic  i_clk;
    logic  i_rst_n;
    logic  in_valid;
    logic  in_ready;
    t_req  in_req;
    logic  out_valid;
    logic  out_ready;
    t_rsp  out_rsp;

    int    fail_count;
    int    pending;
    int    checked;
    int    full_rejects;
    int    empty_rejects;

    // Percent chance that each side idles in a given cycle; changed between phases.
    int    send_idle_pct = 26;
    int    recv_idle_pct = 49;
    bit    hold_request  = 1'b0;
    int    mode_count [4];
    int    quiet_cycles  = 0;

    circular_fifo_with_search_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_rsp)
    );

    cfs_result_monitor monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_req),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_rsp),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_rejects  (full_rejects),
        .o_empty_rejects (empty_rejects)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: any accepted request or response resets the count of quiet cycles.
    initial begin
        forever begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Timeout: no handshake for %0d cycles.", STALL_LIMIT);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // Receiver. Ready changes only at the falling edge. When a hold-off is requested the
    // receiver keeps ready low for a fixed stretch, counting the cycles itself, so the
    // block's result register fills and it stops taking requests.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one request and returns at the falling edge after it is accepted. Random
    // idle cycles come first; valid then stays high with a stable payload until accepted.
    task automatic send_req(input t_mode mode, input logic signed [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid     <= 1'b1;
        in_req.mode  <= mode;
        in_req.value <= value;
        mode_count[mode]++;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Chooses an operation from percentage weights; what is left over goes to search.
    function automatic t_mode pick_mode(input int push_w, input int pop_w, input int peek_w);
        int roll;
        roll = $urandom_range(99);
        if (roll < push_w) return MODE_PUSH;
        if (roll < push_w + pop_w) return MODE_POP;
        if (roll < push_w + pop_w + peek_w) return MODE_PEEK;
        return MODE_SEARCH;
    endfunction

    // Values come often from a small pool, so searches hit and duplicates are stored
    // (the first match must win), sometimes from the extremes, otherwise anywhere.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) return $urandom_range(15);
        if (roll < 55) begin
            case ($urandom_range(3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom();
    endfunction

    // A run of random requests with the given operation mix.
    task automatic run_mix(input int count, input int push_w, input int pop_w,
                           input int peek_w);
        repeat (count) send_req(pick_mode(push_w, pop_w, peek_w), pick_value());
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase one: the sender idles less than the receiver.
        send_idle_pct = 26;
        recv_idle_pct = 49;

        // Directed requests. Everything on an empty queue reports empty or not found.
        send_req(MODE_POP, 32'sd0);
        send_req(MODE_PEEK, 32'sd0);
        send_req(MODE_SEARCH, 32'sd0);
        // Field extremes, with a repeated word so the search must report its first copy.
        send_req(MODE_PUSH, 32'sh7FFF_FFFF);
        send_req(MODE_PUSH, 32'sh8000_0000);
        send_req(MODE_PUSH, 32'sd0);
        send_req(MODE_PUSH, -32'sd1);
        send_req(MODE_PUSH, 32'sh8000_0000);
        send_req(MODE_PEEK, 32'sd0);
        send_req(MODE_SEARCH, 32'sh7FFF_FFFF);
        send_req(MODE_SEARCH, 32'sh8000_0000);
        send_req(MODE_SEARCH, -32'sd1);
        send_req(MODE_SEARCH, 32'sd12345);
        send_req(MODE_POP, 32'sd0);
        send_req(MODE_POP, 32'sd0);
        // After two pops the surviving duplicate sits at offset two from the head.
        send_req(MODE_SEARCH, 32'sh8000_0000);
        send_req(MODE_PEEK, 32'sd0);
        // Drain to empty, then pop and search on the empty queue again.
        repeat (3) send_req(MODE_POP, 32'sd0);
        send_req(MODE_POP, 32'sd0);
        send_req(MODE_SEARCH, -32'sd1);
        send_req(MODE_PUSH, 32'sd5);
        send_req(MODE_POP, 32'sd0);

        // Random part. A push-heavy run fills the queue and keeps pushing into a full one,
        // with deep searches along the way; a mixed run follows.
        run_mix(150, 90, 2, 3);
        run_mix(50, 30, 30, 20);

        // Phase two: the roles swap, and a pop-heavy run drains past empty.
        send_idle_pct = 49;
        recv_idle_pct = 26;
        run_mix(150, 4, 88, 4);
        run_mix(40, 35, 30, 15);

        // Phase three: no idling on either side. The receiver first holds off for a long
        // stretch while requests keep coming, then the queue is filled and drained again.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        run_mix(160, 90, 2, 3);
        run_mix(90, 3, 90, 4);
        in_valid <= 1'b0;

        // Wait for every outstanding response, then a few more cycles so that a stray
        // extra response would still be caught.
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Sent %0d requests: %0d push, %0d pop, %0d peek, %0d search; %0d responses checked.",
                 mode_count[MODE_PUSH] + mode_count[MODE_POP] + mode_count[MODE_PEEK]
                 + mode_count[MODE_SEARCH], mode_count[MODE_PUSH], mode_count[MODE_POP],
                 mode_count[MODE_PEEK], mode_count[MODE_SEARCH], checked);
        $display("Pushes refused on a full queue: %0d; pops or peeks on an empty queue: %0d.",
                 full_rejects, empty_rejects);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
